@@ rtl/stwn_pkg.sv @@
// ----------------------------------------------------------------------------
// stwn_pkg: shared types and constants
// Widths, list defaults and the cell control word of the top-k weight
// normalizer.
// ----------------------------------------------------------------------------
package stwn_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int ID_W           = 8;
    localparam int W_W            = 16;
    localparam int CFG_W          = 5;
    localparam int SUM_W          = W_W + $clog2(MAX_OUT);
    localparam int Q_W            = 16;

    localparam logic [W_W-1:0]   ONE_Q15    = 16'd32768;
    localparam logic [CFG_W-1:0] MJ_RESET   = 5'd3;
    localparam logic [CFG_W-1:0] MJ_MAX     = 5'd16;

    localparam logic REQ_ADD      = 1'b0;
    localparam logic REQ_FINALIZE = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op        op;
        logic [ID_W-1:0] id;
        logic [W_W-1:0]  w;
    } t_cell_ctrl;

endpackage

@@ rtl/stwn_if.sv @@
// ----------------------------------------------------------------------------
// stwn_in_if / stwn_out_if: valid/ready channels
// Input channel carries add/finalize requests, output channel carries results.
// ----------------------------------------------------------------------------
interface stwn_in_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [stwn_pkg::ID_W-1:0] joint_id;
    logic [stwn_pkg::W_W-1:0]  weight_in;

    modport source (output valid, req_type, joint_id, weight_in, input ready);
    modport sink   (input valid, req_type, joint_id, weight_in, output ready);
endinterface

interface stwn_out_if;
    logic                      valid;
    logic                      ready;
    logic [stwn_pkg::ID_W-1:0] out_joint_id;
    logic [stwn_pkg::W_W-1:0]  out_weight;
    logic                      last_of_run;

    modport source (output valid, out_joint_id, out_weight, last_of_run, input ready);
    modport sink   (input valid, out_joint_id, out_weight, last_of_run, output ready);
endinterface

@@ rtl/stwn_cell.sv @@
// ----------------------------------------------------------------------------
// stwn_cell: one list position
// Holds one (id, weight) pair; compares against a new weight, takes the new
// pair or its upper neighbor on insert, and takes its lower neighbor on rotate.
// ----------------------------------------------------------------------------
module stwn_cell (
    input  logic                      i_clk,
    input  stwn_pkg::t_cell_ctrl      i_ctrl,
    input  logic                      i_valid,
    input  logic                      i_prev_ge,
    input  logic [stwn_pkg::ID_W-1:0] i_prev_id,
    input  logic [stwn_pkg::W_W-1:0]  i_prev_w,
    input  logic [stwn_pkg::ID_W-1:0] i_next_id,
    input  logic [stwn_pkg::W_W-1:0]  i_next_w,
    output logic                      o_ge,
    output logic [stwn_pkg::ID_W-1:0] o_id,
    output logic [stwn_pkg::W_W-1:0]  o_w
);

    logic [stwn_pkg::ID_W-1:0] r_id, n_id;
    logic [stwn_pkg::W_W-1:0]  r_w, n_w;

    // equal weights stay ahead of the new entry
    assign o_ge = i_valid && (r_w >= i_ctrl.w);
    assign o_id = r_id;
    assign o_w  = r_w;

    always_comb begin
        n_id = r_id;
        n_w  = r_w;
        case (i_ctrl.op)
            stwn_pkg::CELL_INSERT: begin
                if (!o_ge) begin
                    if (i_prev_ge) begin
                        n_id = i_ctrl.id;
                        n_w  = i_ctrl.w;
                    end else begin
                        n_id = i_prev_id;
                        n_w  = i_prev_w;
                    end
                end
            end
            stwn_pkg::CELL_ROTATE: begin
                n_id = i_next_id;
                n_w  = i_next_w;
            end
            default: begin
                n_id = r_id;
                n_w  = r_w;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        r_w  <= n_w;
    end

endmodule

@@ rtl/stwn_div.sv @@
// ----------------------------------------------------------------------------
// stwn_div: radix-2 restoring divider
// Computes floor(w * 32768 / total), one quotient bit per cycle.
// The caller guarantees 0 < w <= total or w = 0 with total > 0.
// ----------------------------------------------------------------------------
module stwn_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [stwn_pkg::W_W-1:0]   i_w,
    input  logic [stwn_pkg::SUM_W-1:0] i_total,
    output logic                       o_done,
    output logic [stwn_pkg::Q_W-1:0]   o_q
);

    localparam int CNT_W = $clog2(stwn_pkg::Q_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(stwn_pkg::Q_W - 1);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [stwn_pkg::SUM_W-1:0]  r_rem, n_rem;
    logic [stwn_pkg::Q_W-1:0]    r_q, n_q;
    logic [stwn_pkg::SUM_W-1:0]  r_d, n_d;
    logic [stwn_pkg::SUM_W:0]    trial;
    logic                        fits;

    assign trial = {r_rem, r_q[stwn_pkg::Q_W-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        if (i_start) begin
            // numerator is w << 15: high part w >> 1, low bits {w[0], zeros}
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = stwn_pkg::SUM_W'(i_w >> 1);
            n_q    = {i_w[0], {(stwn_pkg::Q_W-1){1'b0}}};
            n_d    = i_total;
        end else if (r_busy) begin
            n_rem = fits ? stwn_pkg::SUM_W'(trial - {1'b0, r_d})
                         : trial[stwn_pkg::SUM_W-1:0];
            n_q   = {r_q[stwn_pkg::Q_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

@@ rtl/sorted_topk_weight_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// sorted_topk_weight_normalizer_core: sorted top-k joint weight list
// Add: the cell row places the pair in one step; next item follows in idle.
// Finalize, list not cut: each result takes a load step and a transfer step with ready high.
// Finalize, list cut: a full rotation of the row sums the top entries, then
// each result passes through the 16-step shared divider.
// Reset: max_joints returns to 3 and the list is empty; stores hold no reset.
// ----------------------------------------------------------------------------
module sorted_topk_weight_normalizer_core #(
    parameter int LIST_DEPTH = stwn_pkg::LIST_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    stwn_in_if.sink                    i_in,
    stwn_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [stwn_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int STEP_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [STEP_W-1:0] LAST_ROT  = STEP_W'(LIST_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // load is folded into every exit to S_DIV and transfers through r_load
    t_state                        r_state, n_state;
    logic                          r_load, n_load;
    logic [stwn_pkg::CFG_W-1:0]    r_max_joints;
    logic [stwn_pkg::CFG_W-1:0]    r_m, n_m;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_cut, n_cut;
    logic [STEP_W-1:0]             r_step, n_step;
    logic [stwn_pkg::SUM_W-1:0]    r_total, n_total;
    logic [stwn_pkg::CFG_W-1:0]    r_k, n_k;
    logic [stwn_pkg::ID_W-1:0]     r_out_id, n_out_id;
    logic [stwn_pkg::W_W-1:0]      r_out_w, n_out_w;
    logic                          r_out_last, n_out_last;

    stwn_pkg::t_cell_ctrl          cell_ctrl;
    logic [stwn_pkg::ID_W-1:0]     cell_id [LIST_DEPTH];
    logic [stwn_pkg::W_W-1:0]      cell_w  [LIST_DEPTH];
    logic                          cell_ge [LIST_DEPTH];

    logic                          in_xfer, out_xfer;
    logic [stwn_pkg::CFG_W-1:0]    m_eff;
    logic                          k_held;
    logic                          div_start, div_done;
    logic [stwn_pkg::Q_W-1:0]      div_q;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.out_joint_id = r_out_id;
    assign o_out.out_weight   = r_out_w;
    assign o_out.last_of_run  = r_out_last;

    always_comb begin
        if (r_max_joints == '0) begin
            m_eff = stwn_pkg::CFG_W'(1);
        end else if (r_max_joints > stwn_pkg::MJ_MAX) begin
            m_eff = stwn_pkg::MJ_MAX;
        end else begin
            m_eff = r_max_joints;
        end
    end

    assign k_held = 8'(r_k) < 8'(r_count);

    // cell row
    always_comb begin
        cell_ctrl.op = stwn_pkg::CELL_HOLD;
        cell_ctrl.id = i_in.joint_id;
        cell_ctrl.w  = i_in.weight_in;
        if (in_xfer && (i_in.req_type == stwn_pkg::REQ_ADD)) begin
            cell_ctrl.op = stwn_pkg::CELL_INSERT;
        end else if ((r_state == S_SUM) || out_xfer) begin
            cell_ctrl.op = stwn_pkg::CELL_ROTATE;
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == LIST_DEPTH - 1) ? 0 : g + 1;
        stwn_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (cell_ctrl),
            .i_valid   (CNT_W'(g) < r_count),
            .i_prev_ge ((g == 0) ? 1'b1 : cell_ge[PREV]),
            .i_prev_id (cell_id[PREV]),
            .i_prev_w  (cell_w[PREV]),
            .i_next_id (cell_id[NEXT]),
            .i_next_w  (cell_w[NEXT]),
            .o_ge      (cell_ge[g]),
            .o_id      (cell_id[g]),
            .o_w       (cell_w[g])
        );
    end

    stwn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_w     (cell_w[0]),
        .i_total (r_total),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_load     = 1'b0;
        n_m        = r_m;
        n_count    = r_count;
        n_cut      = r_cut;
        n_step     = r_step;
        n_total    = r_total;
        n_k        = r_k;
        n_out_id   = r_out_id;
        n_out_w    = r_out_w;
        n_out_last = r_out_last;
        div_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.req_type == stwn_pkg::REQ_FINALIZE) begin
                        n_m     = m_eff;
                        n_cut   = 8'(r_count) > 8'(m_eff);
                        n_k     = '0;
                        n_step  = '0;
                        n_total = '0;
                        if (8'(r_count) > 8'(m_eff)) begin
                            n_state = S_SUM;
                        end else begin
                            n_state = S_DIV;
                            n_load  = 1'b1;
                        end
                    end else if (r_count < DEPTH_CNT) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_SUM: begin
                // full rotation restores the order; add the leading m weights
                if (8'(r_step) < 8'(r_m)) begin
                    n_total = r_total + stwn_pkg::SUM_W'(cell_w[0]);
                end
                n_step = r_step + 1'b1;
                if (r_step == LAST_ROT) begin
                    n_state = S_DIV;
                    n_load  = 1'b1;
                end
            end
            S_DIV: begin
                if (r_load) begin
                    n_out_id   = k_held ? cell_id[0] : '0;
                    n_out_last = (r_k == r_m - 1'b1);
                    if (k_held && r_cut && (r_total != '0)) begin
                        div_start = 1'b1;
                    end else begin
                        n_out_w = (k_held && !r_cut) ? cell_w[0] : '0;
                        n_state = S_OUT;
                    end
                end else if (div_done) begin
                    n_out_w = (div_q > stwn_pkg::ONE_Q15) ? stwn_pkg::ONE_Q15 : div_q;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (r_out_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_load  = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load       <= 1'b0;
            r_count      <= '0;
            r_max_joints <= stwn_pkg::MJ_RESET;
        end else begin
            r_state <= n_state;
            r_load  <= n_load;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_max_joints <= i_cfg_data;
            end
        end
        r_m        <= n_m;
        r_cut      <= n_cut;
        r_step     <= n_step;
        r_total    <= n_total;
        r_k        <= n_k;
        r_out_id   <= n_out_id;
        r_out_w    <= n_out_w;
        r_out_last <= n_out_last;
    end

    // checks
    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_k < r_m))
        else $error("result index beyond run length");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.last_of_run) |=> (r_state == S_IDLE) && (r_count == '0))
        else $error("list not cleared after last transfer");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in.req_type == stwn_pkg::REQ_ADD) && (r_count < DEPTH_CNT))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry count did not advance on add");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

endmodule
